@@ sv/rcm_pkg.sv @@
`timescale 1ns / 1ps
// shared types and defaults of the rendezvous channel matcher
package rcm_pkg;

	localparam int PROC_COUNT_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int PID_W           = 4;
	localparam int DATA_W          = 32;

	typedef enum logic [1:0] {
		REQ_SEND        = 2'd0,
		REQ_RECV        = 2'd1,
		REQ_CANCEL_SEND = 2'd2,
		REQ_CANCEL_RECV = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ACT_DELIVER = 3'd0,
		ACT_AWAKEN  = 3'd1,
		ACT_SLEEP   = 3'd2,
		ACT_SELECT  = 3'd3,
		ACT_ANON    = 3'd4,
		ACT_CANCEL  = 3'd5
	} action_t;

	typedef struct packed {
		req_kind_t         req_type;
		logic [PID_W-1:0]  proc_id;
		logic              has_proc;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		action_t           action;
		logic [PID_W-1:0]  target_proc;
		logic [DATA_W-1:0] out_value;
		logic              found;
		logic              overflow;
		logic              receivers_waiting;
		logic              senders_waiting;
		logic              last;
	} rsp_t;

endpackage

@@ sv/rendezvous_channel_matcher_core.sv @@
`timescale 1ns / 1ps
// rendezvous channel matcher: request decode, queue memories and result sequencing
//
// Requests enter on the req channel (valid/ready), one at a time: send, receive,
// cancel of a queued send, cancel of a queued receive. Each request answers with
// one to four result beats on the rsp channel (valid/ready); the final beat of a
// request carries last.
// Waiting receivers, queued senders, anonymous values and the per-process stored
// values sit in synchronous memories with registered read ports. Queues are
// circular buffers with head, tail and fill count; the queue heads are read while
// the block is idle so the data is ready in the cycle after acceptance.
// Send and receive are decided in S_READ, with S_PEND added when a receive has
// to fetch the value stored by a real sender; S_EMIT then loads one result beat
// per cycle into the output register while the receiver keeps up, and the block
// returns to idle. A cancel walks its queue in S_SCAN one entry a cycle, reading
// ahead while shifting later entries down over the removed one. A new request is
// taken while the last beat still waits in the output register; an earlier beat
// held by a stalled receiver holds the sequencer.
// Reset empties all queues at once; the memories themselves are not cleared.
module rendezvous_channel_matcher_core #(
	parameter int PROC_COUNT  = rcm_pkg::PROC_COUNT_DEF,
	parameter int QUEUE_DEPTH = rcm_pkg::QUEUE_DEPTH_DEF,
	parameter int VALUE_WIDTH = rcm_pkg::VALUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rcm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rcm_pkg::rsp_t rsp
);

	localparam int PID_W = rcm_pkg::PID_W;
	localparam int QW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int PW    = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
	localparam int SW    = (VALUE_WIDTH < rcm_pkg::DATA_W) ? VALUE_WIDTH : rcm_pkg::DATA_W;
	localparam int NPID  = 2 ** PID_W;

	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);
	localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_DEPTH - 1);
	localparam logic [QW-1:0] PTR_ONE  = QW'(1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_PEND = 5'b00100,
		S_SCAN = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	typedef struct packed {
		rcm_pkg::action_t action;
		logic [PID_W-1:0] tgt;
		logic [SW-1:0]    val;
		logic             found;
		logic             ovf;
	} res_t;

	function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_ONE;
	endfunction

	function automatic logic [QW-1:0] ptr_dec(input logic [QW-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_ONE;
	endfunction

	function automatic res_t mk_res(input rcm_pkg::action_t act, input logic [PID_W-1:0] tgt,
			input logic [SW-1:0] val, input logic fnd, input logic ovf);
		res_t r;
		r.action = act;
		r.tgt    = tgt;
		r.val    = val;
		r.found  = fnd;
		r.ovf    = ovf;
		return r;
	endfunction

	// process id to value store slot
	logic [PW-1:0] pid_map [NPID];
	for (genvar gi = 0; gi < NPID; gi++) begin : g_pid_map
		assign pid_map[gi] = PW'(gi % PROC_COUNT);
	end

	// memories
	logic [PID_W:0]   sq_mem [QUEUE_DEPTH];
	logic [PID_W-1:0] rq_mem [QUEUE_DEPTH];
	logic [SW-1:0]    pv_mem [PROC_COUNT];
	logic [SW-1:0]    av_mem [QUEUE_DEPTH];

	logic [PID_W:0]   sq_rd_q;
	logic [PID_W-1:0] rq_rd_q;
	logic [SW-1:0]    pv_rd_q;
	logic [SW-1:0]    av_rd_q;

	logic             sq_we, rq_we, pv_we, av_we;
	logic [QW-1:0]    sq_wa, sq_ra, rq_wa, rq_ra, av_wa, av_ra;
	logic [PW-1:0]    pv_wa, pv_ra;
	logic [PID_W:0]   sq_wd;
	logic [PID_W-1:0] rq_wd;
	logic [SW-1:0]    pv_wd, av_wd;

	// control and working registers
	state_t           state_q, state_d;
	rcm_pkg::req_t    req_q;
	logic [QW-1:0]    s_head_q, s_head_d, s_tail_q, s_tail_d;
	logic [QW-1:0]    r_head_q, r_head_d, r_tail_q, r_tail_d;
	logic [QW-1:0]    a_head_q, a_head_d, a_tail_q, a_tail_d;
	logic [CW-1:0]    s_cnt_q, s_cnt_d, r_cnt_q, r_cnt_d, a_cnt_q, a_cnt_d;
	logic [PID_W-1:0] sp_q, sp_d;
	logic [QW-1:0]    p_q, p_d, pm_q, pm_d, off_q, off_d;
	logic             found_q, found_d;
	res_t             res_q [4];
	res_t             res_d [4];
	logic [1:0]       last_idx_q, last_idx_d, k_q, k_d;
	rcm_pkg::rsp_t    rsp_q;
	logic             rsp_valid_q;
	logic             rsp_load;
	logic [SW-1:0]    req_val;
	logic             accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign req_val   = req_q.value[SW-1:0];
	assign rsp_load  = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (sq_we) begin
			sq_mem[sq_wa] <= sq_wd;
		end
		sq_rd_q <= sq_mem[sq_ra];
	end

	always_ff @(posedge clk) begin
		if (rq_we) begin
			rq_mem[rq_wa] <= rq_wd;
		end
		rq_rd_q <= rq_mem[rq_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			pv_mem[pv_wa] <= pv_wd;
		end
		pv_rd_q <= pv_mem[pv_ra];
	end

	always_ff @(posedge clk) begin
		if (av_we) begin
			av_mem[av_wa] <= av_wd;
		end
		av_rd_q <= av_mem[av_ra];
	end

	always_comb begin
		logic          hit;
		logic          fnd;
		logic          done;
		logic          scan_send;
		logic [CW-1:0] scan_cnt;
		logic [SW-1:0] anon_val;

		state_d    = state_q;
		s_head_d   = s_head_q;
		s_tail_d   = s_tail_q;
		s_cnt_d    = s_cnt_q;
		r_head_d   = r_head_q;
		r_tail_d   = r_tail_q;
		r_cnt_d    = r_cnt_q;
		a_head_d   = a_head_q;
		a_tail_d   = a_tail_q;
		a_cnt_d    = a_cnt_q;
		sp_d       = sp_q;
		p_d        = p_q;
		pm_d       = pm_q;
		off_d      = off_q;
		found_d    = found_q;
		res_d      = res_q;
		last_idx_d = last_idx_q;
		k_d        = k_q;

		// heads are read every idle cycle
		sq_ra = s_head_q;
		rq_ra = r_head_q;
		av_ra = a_head_q;
		pv_ra = pid_map[sq_rd_q[PID_W-1:0]];
		sq_we = 1'b0;
		sq_wa = s_tail_q;
		sq_wd = {1'b1, req_q.proc_id};
		rq_we = 1'b0;
		rq_wa = r_tail_q;
		rq_wd = req_q.proc_id;
		pv_we = 1'b0;
		pv_wa = pid_map[req_q.proc_id];
		pv_wd = req_val;
		av_we = 1'b0;
		av_wa = a_tail_q;
		av_wd = req_val;

		hit       = 1'b0;
		fnd       = 1'b0;
		done      = 1'b0;
		scan_send = (req_q.req_type == rcm_pkg::REQ_CANCEL_SEND);
		scan_cnt  = scan_send ? s_cnt_q : r_cnt_q;
		anon_val  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					p_d     = (req.req_type == rcm_pkg::REQ_CANCEL_SEND) ? s_head_q : r_head_q;
					off_d   = '0;
					found_d = 1'b0;
					if (req.req_type == rcm_pkg::REQ_CANCEL_SEND ||
							req.req_type == rcm_pkg::REQ_CANCEL_RECV) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_READ;
					end
				end
			end

			S_READ: begin
				state_d    = S_EMIT;
				k_d        = '0;
				last_idx_d = '0;
				if (req_q.req_type == rcm_pkg::REQ_SEND) begin
					if (r_cnt_q != '0) begin
						r_head_d = ptr_inc(r_head_q);
						r_cnt_d  = r_cnt_q - CNT_ONE;
						res_d[0] = mk_res(rcm_pkg::ACT_DELIVER, rq_rd_q, req_val, 1'b0, 1'b0);
						if (req_q.has_proc) begin
							res_d[1]   = mk_res(rcm_pkg::ACT_SELECT, req_q.proc_id, '0,
								1'b0, 1'b0);
							res_d[2]   = mk_res(rcm_pkg::ACT_SELECT, rq_rd_q, '0, 1'b0, 1'b0);
							res_d[3]   = mk_res(rcm_pkg::ACT_AWAKEN, rq_rd_q, '0, 1'b0, 1'b0);
							last_idx_d = 2'd3;
						end else begin
							res_d[1]   = mk_res(rcm_pkg::ACT_SELECT, rq_rd_q, '0, 1'b0, 1'b0);
							res_d[2]   = mk_res(rcm_pkg::ACT_AWAKEN, rq_rd_q, '0, 1'b0, 1'b0);
							last_idx_d = 2'd2;
						end
					end else if (req_q.has_proc) begin
						res_d[0] = mk_res(rcm_pkg::ACT_SLEEP, req_q.proc_id, '0, 1'b0,
							s_cnt_q == CNT_FULL);
						if (s_cnt_q != CNT_FULL) begin
							pv_we    = 1'b1;
							sq_we    = 1'b1;
							s_tail_d = ptr_inc(s_tail_q);
							s_cnt_d  = s_cnt_q + CNT_ONE;
						end
					end else begin
						res_d[0] = mk_res(rcm_pkg::ACT_ANON, '0, '0, 1'b0,
							s_cnt_q == CNT_FULL || a_cnt_q == CNT_FULL);
						if (s_cnt_q != CNT_FULL && a_cnt_q != CNT_FULL) begin
							av_we    = 1'b1;
							sq_we    = 1'b1;
							sq_wd    = '0;
							s_tail_d = ptr_inc(s_tail_q);
							s_cnt_d  = s_cnt_q + CNT_ONE;
							a_tail_d = ptr_inc(a_tail_q);
							a_cnt_d  = a_cnt_q + CNT_ONE;
						end
					end
				end else begin
					if (s_cnt_q != '0) begin
						s_head_d = ptr_inc(s_head_q);
						s_cnt_d  = s_cnt_q - CNT_ONE;
						if (sq_rd_q[PID_W]) begin
							// stored value is read this cycle, results next
							sp_d    = sq_rd_q[PID_W-1:0];
							state_d = S_PEND;
						end else begin
							if (a_cnt_q != '0) begin
								anon_val = av_rd_q;
								a_head_d = ptr_inc(a_head_q);
								a_cnt_d  = a_cnt_q - CNT_ONE;
							end
							res_d[0]   = mk_res(rcm_pkg::ACT_DELIVER, req_q.proc_id, anon_val,
								1'b0, 1'b0);
							res_d[1]   = mk_res(rcm_pkg::ACT_SELECT, req_q.proc_id, '0,
								1'b0, 1'b0);
							last_idx_d = 2'd1;
						end
					end else begin
						res_d[0] = mk_res(rcm_pkg::ACT_SLEEP, req_q.proc_id, '0, 1'b0,
							r_cnt_q == CNT_FULL);
						if (r_cnt_q != CNT_FULL) begin
							rq_we    = 1'b1;
							r_tail_d = ptr_inc(r_tail_q);
							r_cnt_d  = r_cnt_q + CNT_ONE;
						end
					end
				end
			end

			S_PEND: begin
				state_d    = S_EMIT;
				k_d        = '0;
				res_d[0]   = mk_res(rcm_pkg::ACT_DELIVER, req_q.proc_id, pv_rd_q, 1'b0, 1'b0);
				res_d[1]   = mk_res(rcm_pkg::ACT_AWAKEN, sp_q, '0, 1'b0, 1'b0);
				res_d[2]   = mk_res(rcm_pkg::ACT_SELECT, req_q.proc_id, '0, 1'b0, 1'b0);
				res_d[3]   = mk_res(rcm_pkg::ACT_SELECT, sp_q, '0, 1'b0, 1'b0);
				last_idx_d = 2'd3;
			end

			S_SCAN: begin
				// data of entry off_q is in the read register; read ahead, and once
				// the match is behind us move each entry down by one slot
				if (scan_send) begin
					hit   = (sq_rd_q == {1'b1, req_q.proc_id});
					sq_ra = ptr_inc(p_q);
					sq_wa = pm_q;
					sq_wd = sq_rd_q;
					sq_we = found_q;
				end else begin
					hit   = (rq_rd_q == req_q.proc_id);
					rq_ra = ptr_inc(p_q);
					rq_wa = pm_q;
					rq_wd = rq_rd_q;
					rq_we = found_q;
				end
				if (scan_cnt == '0) begin
					done = 1'b1;
				end else begin
					done    = ((CW'(off_q) + CNT_ONE) == scan_cnt);
					fnd     = found_q || hit;
					found_d = fnd;
				end
				if (done) begin
					if (fnd) begin
						if (scan_send) begin
							s_cnt_d  = s_cnt_q - CNT_ONE;
							s_tail_d = ptr_dec(s_tail_q);
						end else begin
							r_cnt_d  = r_cnt_q - CNT_ONE;
							r_tail_d = ptr_dec(r_tail_q);
						end
					end
					res_d[0]   = mk_res(rcm_pkg::ACT_CANCEL, req_q.proc_id, '0, fnd, 1'b0);
					last_idx_d = '0;
					k_d        = '0;
					state_d    = S_EMIT;
				end else begin
					pm_d  = p_q;
					p_d   = ptr_inc(p_q);
					off_d = off_q + PTR_ONE;
				end
			end

			S_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					k_d = k_q + 2'd1;
					if (k_q == last_idx_q) begin
						state_d = S_IDLE;
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			s_head_q <= '0;
			s_tail_q <= '0;
			s_cnt_q  <= '0;
			r_head_q <= '0;
			r_tail_q <= '0;
			r_cnt_q  <= '0;
			a_head_q <= '0;
			a_tail_q <= '0;
			a_cnt_q  <= '0;
		end else begin
			state_q  <= state_d;
			s_head_q <= s_head_d;
			s_tail_q <= s_tail_d;
			s_cnt_q  <= s_cnt_d;
			r_head_q <= r_head_d;
			r_tail_q <= r_tail_d;
			r_cnt_q  <= r_cnt_d;
			a_head_q <= a_head_d;
			a_tail_q <= a_tail_d;
			a_cnt_q  <= a_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		sp_q       <= sp_d;
		p_q        <= p_d;
		pm_q       <= pm_d;
		off_q      <= off_d;
		found_q    <= found_d;
		res_q      <= res_d;
		last_idx_q <= last_idx_d;
		k_q        <= k_d;
	end

	// output register: one beat per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.action            <= res_q[k_q].action;
			rsp_q.target_proc       <= res_q[k_q].tgt;
			rsp_q.out_value         <= rcm_pkg::DATA_W'(res_q[k_q].val);
			rsp_q.found             <= res_q[k_q].found;
			rsp_q.overflow          <= res_q[k_q].ovf;
			rsp_q.receivers_waiting <= (r_cnt_q != '0);
			rsp_q.senders_waiting   <= (s_cnt_q != '0);
			rsp_q.last              <= (k_q == last_idx_q);
		end
	end

endmodule
